[hdl/orwa_pkg.sv]
// ----------------------------------------------------------------------------
// orwa_pkg: shared types and constants of the trimmed window average
// Word formats between the front, the queue, the back and the divider.
// ----------------------------------------------------------------------------
package orwa_pkg;

  localparam int RAW_W     = 16;
  localparam int SAMPLE_W  = 10;
  localparam int PERIOD_W  = 16;
  localparam int PULSE_W   = 16;
  localparam int PROD_W    = PERIOD_W + SAMPLE_W;
  localparam int DIV_W     = 14;
  localparam int DIVISOR_W = 10;

  localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX   = 10'd1023;
  localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 16'd1000;
  localparam int BAND_LO_NUM = 9;
  localparam int BAND_HI_NUM = 11;
  localparam int BAND_RCP    = 26215;
  localparam int BAND_RCP_SH = 18;
  localparam int BAND_PROD_W = 29;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                oor;
  } q_word_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_stat_t;

endpackage

[hdl/orwa_front.sv]
// ----------------------------------------------------------------------------
// orwa_front: input side of the trimmed window average
// Accepts raw samples, replaces out-of-range readings by zero and flags them.
// ----------------------------------------------------------------------------
module orwa_front (
  input  logic [orwa_pkg::RAW_W-1:0] raw_sample,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       q_full,
  output logic                       q_push,
  output orwa_pkg::q_word_t          q_word
);
  import orwa_pkg::*;

  logic out_of_range;

  assign out_of_range  = raw_sample > RAW_W'(SAMPLE_MAX);
  assign in_ready      = !q_full;
  assign q_push        = in_valid && !q_full;
  assign q_word.oor    = out_of_range;
  assign q_word.sample = out_of_range ? '0 : raw_sample[SAMPLE_W-1:0];

endmodule

[hdl/orwa_queue.sv]
// ----------------------------------------------------------------------------
// orwa_queue: two-word queue between front and back
// Lets the front keep accepting while the back works on an earlier sample.
// ----------------------------------------------------------------------------
module orwa_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  orwa_pkg::q_word_t push_word,
  output logic              full,
  input  logic              pop,
  output orwa_pkg::q_word_t pop_word,
  output logic              empty
);
  import orwa_pkg::*;

  localparam int DEPTH = 2;

  q_word_t    mem [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'(DEPTH);
  assign empty    = count == 2'd0;
  assign pop_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

[hdl/orwa_div.sv]
// ----------------------------------------------------------------------------
// orwa_div: restoring divider
// One quotient bit per cycle; done rises when the quotient is ready.
// ----------------------------------------------------------------------------
module orwa_div (
  input  logic                clk,
  input  logic                rst,
  input  orwa_pkg::div_req_t  req,
  output orwa_pkg::div_stat_t stat
);
  import orwa_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     step;
  logic [DIVISOR_W:0]   rem;
  logic [DIV_W-1:0]     quo;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W+1:0] rem_shift;
  logic                 fits;

  assign rem_shift = {rem, quo[DIV_W-1]};
  assign fits      = rem_shift >= {2'b00, dsr};

  assign stat.busy     = busy;
  assign stat.done     = done;
  assign stat.quotient = quo;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= (DIVISOR_W+1)'(rem_shift - {2'b00, dsr});
      end else begin
        rem <= rem_shift[DIVISOR_W:0];
      end
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + CNT_W'(1);
        if (step == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");

endmodule

[hdl/orwa_back.sv]
// ----------------------------------------------------------------------------
// orwa_back: window update, band selection and output register
// Walks the ring window twice per sample and sequences the divider for the level.
// ----------------------------------------------------------------------------
module orwa_back #(
  parameter int WINDOW_LENGTH = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [orwa_pkg::PERIOD_W-1:0] period,
  input  logic                          q_empty,
  input  orwa_pkg::q_word_t             q_word,
  output logic                          q_pop,
  output orwa_pkg::div_req_t            div_req,
  input  orwa_pkg::div_stat_t           div_stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [orwa_pkg::SAMPLE_W-1:0] filtered_level,
  output logic [orwa_pkg::PULSE_W-1:0]  pulse_width_us,
  output logic                          sample_out_of_range,
  output logic                          band_empty
);
  import orwa_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_LENGTH);
  localparam int SUM_W = $clog2(WINDOW_LENGTH * 1023 + 1);
  localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);
  localparam int BND_W = SAMPLE_W + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LENGTH - 1);

  localparam int MEAN_SH     = SUM_W + $clog2(WINDOW_LENGTH);
  localparam int MEAN_PROD_W = 2 * SUM_W + 2;
  localparam logic [MEAN_PROD_W-1:0] MEAN_MUL =
    MEAN_PROD_W'((2 ** MEAN_SH + WINDOW_LENGTH - 1) / WINDOW_LENGTH);
  localparam logic [BAND_PROD_W-1:0] LO_MUL = BAND_PROD_W'(BAND_LO_NUM * BAND_RCP);
  localparam logic [BAND_PROD_W-1:0] HI_MUL = BAND_PROD_W'(BAND_HI_NUM * BAND_RCP);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SUM     = 4'd1;
  localparam logic [3:0] S_MEAN    = 4'd2;
  localparam logic [3:0] S_BOUND   = 4'd3;
  localparam logic [3:0] S_BAND    = 4'd4;
  localparam logic [3:0] S_W_LVL   = 4'd5;
  localparam logic [3:0] S_PW_MUL  = 4'd6;
  localparam logic [3:0] S_PW_FOLD = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  logic [3:0]          state;
  logic [SAMPLE_W-1:0] win [WINDOW_LENGTH];
  logic [IDX_W-1:0]    wp;
  logic [IDX_W-1:0]    idx;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] mean;
  logic [BND_W-1:0]    lo;
  logic [BND_W-1:0]    hi;
  logic [SUM_W-1:0]    bsum;
  logic [CNT_W-1:0]    cnt;
  logic [SAMPLE_W-1:0] level;
  logic [SAMPLE_W-1:0] last_level;
  logic [PULSE_W-1:0]  pw;
  logic [PULSE_W-1:0]  pw_q;
  logic [PULSE_W:0]    pw_r;
  logic                oor;
  logic                empty;

  logic [IDX_W-1:0]         wp_next;
  logic [SAMPLE_W-1:0]      win_rd;
  logic [SUM_W-1:0]         sum_next;
  logic                     in_band;
  logic [SUM_W-1:0]         bsum_next;
  logic [CNT_W-1:0]         cnt_next;
  logic [SAMPLE_W-1:0]      q_low;
  logic [MEAN_PROD_W-1:0]   mean_prod;
  logic [BAND_PROD_W-1:0]   lo_prod;
  logic [BAND_PROD_W-1:0]   hi_prod;
  logic [PROD_W-1:0]        pulse_prod;
  logic [PULSE_W-SAMPLE_W:0] pw_carry;
  logic                     out_free;

  assign wp_next    = (wp == IDX_LAST) ? '0 : wp + IDX_W'(1);
  assign win_rd     = win[idx];
  assign sum_next   = sum + SUM_W'(win_rd);
  assign in_band    = ({1'b0, win_rd} >= lo) && ({1'b0, win_rd} <= hi);
  assign bsum_next  = in_band ? bsum + SUM_W'(win_rd) : bsum;
  assign cnt_next   = in_band ? cnt + CNT_W'(1) : cnt;
  assign q_low      = div_stat.quotient[SAMPLE_W-1:0];
  assign mean_prod  = MEAN_PROD_W'(sum) * MEAN_MUL;
  assign lo_prod    = BAND_PROD_W'(mean) * LO_MUL;
  assign hi_prod    = BAND_PROD_W'(mean) * HI_MUL;
  assign pulse_prod = PROD_W'(period) * PROD_W'(level);
  assign pw_carry   = pw_r[PULSE_W:SAMPLE_W];
  assign out_free   = !out_valid || out_ready;
  assign q_pop      = (state == S_IDLE) && !q_empty;

  always_comb begin
    div_req = '0;
    if (state == S_BAND && idx == IDX_LAST && cnt_next != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'(bsum_next);
      div_req.divisor  = DIVISOR_W'(cnt_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wp         <= IDX_LAST;
      idx        <= '0;
      last_level <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            win[wp_next] <= q_word.sample;
            wp           <= wp_next;
            oor          <= q_word.oor;
            sum          <= '0;
            idx          <= '0;
            state        <= S_SUM;
          end
        end
        S_SUM: begin
          sum <= sum_next;
          if (idx == IDX_LAST) begin
            state <= S_MEAN;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_MEAN: begin
          mean  <= mean_prod[MEAN_SH +: SAMPLE_W];
          state <= S_BOUND;
        end
        S_BOUND: begin
          lo    <= lo_prod[BAND_RCP_SH +: BND_W];
          hi    <= hi_prod[BAND_RCP_SH +: BND_W];
          idx   <= '0;
          bsum  <= '0;
          cnt   <= '0;
          state <= S_BAND;
        end
        S_BAND: begin
          bsum <= bsum_next;
          cnt  <= cnt_next;
          if (idx == IDX_LAST) begin
            if (cnt_next == '0) begin
              level <= last_level;
              empty <= 1'b1;
              state <= S_PW_MUL;
            end else begin
              empty <= 1'b0;
              state <= S_W_LVL;
            end
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_W_LVL: begin
          if (div_stat.done) begin
            level      <= q_low;
            last_level <= q_low;
            state      <= S_PW_MUL;
          end
        end
        S_PW_MUL: begin
          pw_q  <= pulse_prod[PROD_W-1:SAMPLE_W];
          pw_r  <= (PULSE_W+1)'(pulse_prod[SAMPLE_W-1:0]) +
                   (PULSE_W+1)'(pulse_prod[PROD_W-1:SAMPLE_W]);
          state <= S_PW_FOLD;
        end
        S_PW_FOLD: begin
          if (pw_carry != '0) begin
            pw_q <= pw_q + PULSE_W'(pw_carry);
            pw_r <= (PULSE_W+1)'(pw_r[SAMPLE_W-1:0]) + (PULSE_W+1)'(pw_carry);
          end else begin
            pw    <= (pw_r[SAMPLE_W-1:0] == SAMPLE_MAX) ? pw_q + PULSE_W'(1) : pw_q;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            filtered_level      <= level;
            pulse_width_us      <= pw;
            sample_out_of_range <= oor;
            band_empty          <= empty;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_W_LVL))
    else $error("divider result arrived outside a wait state");

  a_empty_repeats_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free && empty) |=> (filtered_level == last_level))
    else $error("empty band did not repeat the previous level");

endmodule

[hdl/outlier_rejecting_window_average_top.sv]
// ----------------------------------------------------------------------------
// outlier_rejecting_window_average_top: trimmed moving average filter
// Averages the window samples inside a ten percent band around the mean.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, raw_sample) takes one converter word
// per handshake. Each word yields exactly one output word (out_valid,
// out_ready, filtered_level, pulse_width_us, sample_out_of_range, band_empty).
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the PWM
// period and is always ready.
// Words pass through a two-word queue into a sequencer that walks the window
// once for the mean and once for the band. The mean and both band limits come
// from constant reciprocal products, the level from a 14-step divider, and
// the pulse width from a shift-and-add division by 1023.
// Reset clears the window to zero, the last level to zero, the period to
// 1000 and empties the queue and the output register.
// When the receiver stalls, the result holds in the output register, the
// sequencer waits, and the queue still takes up to two more words.
// ----------------------------------------------------------------------------
module outlier_rejecting_window_average_top #(
  parameter int WINDOW_LENGTH = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [orwa_pkg::RAW_W-1:0]    raw_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [orwa_pkg::SAMPLE_W-1:0] filtered_level,
  output logic [orwa_pkg::PULSE_W-1:0]  pulse_width_us,
  output logic                          sample_out_of_range,
  output logic                          band_empty,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [orwa_pkg::PERIOD_W-1:0] cfg_data
);
  import orwa_pkg::*;

  logic [PERIOD_W-1:0] period;
  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  q_word_t             push_word;
  q_word_t             pop_word;
  div_req_t            div_req;
  div_stat_t           div_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_valid) begin
      period <= cfg_data;
    end
  end

  orwa_front u_front (
    .raw_sample (raw_sample),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_word     (push_word)
  );

  orwa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (pop_word),
    .empty     (q_empty)
  );

  orwa_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat)
  );

  orwa_back #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .period              (period),
    .q_empty             (q_empty),
    .q_word              (pop_word),
    .q_pop               (q_pop),
    .div_req             (div_req),
    .div_stat            (div_stat),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .filtered_level      (filtered_level),
    .pulse_width_us      (pulse_width_us),
    .sample_out_of_range (sample_out_of_range),
    .band_empty          (band_empty)
  );

endmodule

[sim/tb_outlier_rejecting_window_average_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_outlier_rejecting_window_average_top: testbench of the trimmed window average
// A short table of directed samples runs first. Then come phases of random
// samples under several PWM periods and handshake idle patterns. A model of
// the window kept here predicts the output words that the table does not give,
// and each word is compared field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module tb_outlier_rejecting_window_average_top;
  import orwa_pkg::*;

  localparam int WIN         = 10;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 230;

  typedef struct {
    logic [SAMPLE_W-1:0] level;
    logic [PULSE_W-1:0]  pulse;
    logic                oor;
    logic                empty;
  } avg_word_t;

  typedef struct {
    logic [RAW_W-1:0] raw;
    bit               typed;
    avg_word_t        word;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [RAW_W-1:0]    raw_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SAMPLE_W-1:0] filtered_level;
  logic [PULSE_W-1:0]  pulse_width_us;
  logic                sample_out_of_range;
  logic                band_empty;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_data = '0;

  logic [SAMPLE_W-1:0] win_model [WIN];
  logic [3:0]          wr_slot;
  logic [SAMPLE_W-1:0] held_level;
  logic [PERIOD_W-1:0] period_model;
  logic [PERIOD_W-1:0] period_list [PHASES];

  avg_word_t expected_words[$];
  dir_row_t  dir_rows[$];
  int        errors     = 0;
  int        send_idle  = 9;
  int        recv_idle  = 55;
  int        base_level = 512;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  outlier_rejecting_window_average_top #(
    .WINDOW_LENGTH(WIN)
  ) dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .raw_sample         (raw_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .filtered_level     (filtered_level),
    .pulse_width_us     (pulse_width_us),
    .sample_out_of_range(sample_out_of_range),
    .band_empty         (band_empty),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  function automatic void reset_model();
    for (int i = 0; i < WIN; i++) begin
      win_model[i] = '0;
    end
    wr_slot      = 4'(WIN - 1);
    held_level   = '0;
    period_model = PERIOD_RESET;
  endfunction

  function automatic avg_word_t predict_average(input logic [RAW_W-1:0] raw);
    avg_word_t           r;
    logic [SAMPLE_W-1:0] smp;
    int unsigned         sum;
    int unsigned         mean;
    int unsigned         lo;
    int unsigned         hi;
    int unsigned         bsum;
    int unsigned         cnt;
    int unsigned         prod;
    r.oor = (raw > RAW_W'(SAMPLE_MAX));
    smp   = r.oor ? '0 : raw[SAMPLE_W-1:0];
    wr_slot = (wr_slot < 4'(WIN - 1)) ? wr_slot + 4'd1 : 4'd0;
    win_model[wr_slot] = smp;
    sum = 0;
    for (int i = 0; i < WIN; i++) begin
      sum += win_model[i];
    end
    mean = sum / WIN;
    lo   = (mean * 9) / 10;
    hi   = (mean * 11) / 10;
    bsum = 0;
    cnt  = 0;
    for (int i = 0; i < WIN; i++) begin
      if (win_model[i] >= lo && win_model[i] <= hi) begin
        bsum += win_model[i];
        cnt++;
      end
    end
    if (cnt > 0) begin
      r.level    = SAMPLE_W'(bsum / cnt);
      r.empty    = 1'b0;
      held_level = r.level;
    end else begin
      r.level = held_level;
      r.empty = 1'b1;
    end
    prod    = period_model;
    prod    = (prod * r.level) / 1023;
    r.pulse = PULSE_W'(prod);
    return r;
  endfunction

  function automatic void add_row(input logic [RAW_W-1:0] raw, input bit typed,
                                  input int level, input int pulse,
                                  input logic oor, input logic empty);
    dir_row_t d;
    d.raw        = raw;
    d.typed      = typed;
    d.word.level = SAMPLE_W'(level);
    d.word.pulse = PULSE_W'(pulse);
    d.word.oor   = oor;
    d.word.empty = empty;
    dir_rows.push_back(d);
  endfunction

  function automatic logic [RAW_W-1:0] random_sample();
    int pick;
    int j;
    int v;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 3) begin
      base_level = $urandom_range(1023);
    end
    if (pick < 50) begin
      j = base_level / 16 + 2;
      v = int'($urandom_range(2 * j));
      v = base_level + v - j;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
    end else if (pick < 65) begin
      v = ($urandom_range(1) == 1) ? 1023 - int'($urandom_range(3)) : int'($urandom_range(3));
    end else if (pick < 80) begin
      v = $urandom_range(1023);
    end else if (pick < 90) begin
      v = $urandom_range(65535);
    end else begin
      case ($urandom_range(3))
        0: v = 0;
        1: v = 1023;
        2: v = 1024;
        default: v = 65535;
      endcase
    end
    return RAW_W'(v);
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    avg_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected output word, expected none, actual level %0d pulse %0d",
                 $time, filtered_level, pulse_width_us);
        errors++;
      end else begin
        e = expected_words.pop_front();
        check_field("filtered_level", e.level, filtered_level);
        check_field("pulse_width_us", e.pulse, pulse_width_us);
        check_field("sample_out_of_range", e.oor, sample_out_of_range);
        check_field("band_empty", e.empty, band_empty);
      end
    end
  end

  task automatic send_sample(input logic [RAW_W-1:0] v, input bit typed,
                             input avg_word_t typed_word);
    avg_word_t w;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_sample <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    w = predict_average(v);
    expected_words.push_back(typed ? typed_word : w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] p);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= p;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    period_model = p;
  endtask

  initial begin
    avg_word_t none;
    none = '{default: '0};
    reset_model();
    period_list = '{16'd65535, 16'd1, 16'd0, 16'd0, 16'd1023, 16'd1000};
    period_list[3] = PERIOD_W'($urandom_range(65534, 2));

    add_row(16'd0, 1'b1, 0, 0, 1'b0, 1'b0);
    add_row(16'hFFFF, 1'b1, 0, 0, 1'b1, 1'b0);
    add_row(16'd1024, 1'b1, 0, 0, 1'b1, 1'b0);
    add_row(16'd1023, 1'b1, 0, 0, 1'b0, 1'b1);
    for (int i = 0; i < 8; i++) begin
      add_row(16'd1023, 1'b0, 0, 0, 1'b0, 1'b0);
    end
    add_row(16'd1023, 1'b1, 1023, 1000, 1'b0, 1'b0);
    add_row(16'd0, 1'b1, 1023, 1000, 1'b0, 1'b1);
    add_row(16'hFFFF, 1'b0, 0, 0, 1'b0, 1'b0);
    add_row(16'd512, 1'b0, 0, 0, 1'b0, 1'b0);
    add_row(16'd1, 1'b0, 0, 0, 1'b0, 1'b0);
    add_row(16'h8000, 1'b0, 0, 0, 1'b0, 1'b0);
    add_row(16'h5555, 1'b0, 0, 0, 1'b0, 1'b0);
    add_row(16'h02AA, 1'b0, 0, 0, 1'b0, 1'b0);
    add_row(16'h0155, 1'b0, 0, 0, 1'b0, 1'b0);
    add_row(16'd1000, 1'b0, 0, 0, 1'b0, 1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_sample(dir_rows[i].raw, dir_rows[i].typed, dir_rows[i].word);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 2) begin
        send_idle = 9;
        recv_idle = 55;
      end else if (ph < 4) begin
        send_idle = 55;
        recv_idle = 9;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_period(period_list[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == PHASE_ITEMS / 2) begin
          drain();
        end
        send_sample(random_sample(), 1'b0, none);
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb_outlier_rejecting_window_average_top: clean");
    end else begin
      $display("tb_outlier_rejecting_window_average_top: errors");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("tb_outlier_rejecting_window_average_top: errors");
    $finish;
  end

endmodule

[outlier_rejecting_window_average_top.f]
hdl/orwa_pkg.sv
hdl/orwa_front.sv
hdl/orwa_queue.sv
hdl/orwa_div.sv
hdl/orwa_back.sv
hdl/outlier_rejecting_window_average_top.sv
sim/tb_outlier_rejecting_window_average_top.sv
